/* hw/rtl/cnh_pkg.sv */
// shared types, codes and the angle-to-sector function for the canny nms/hysteresis block
// no dependencies
package cnh_pkg;

    localparam int MAG_W     = 11;
    localparam int ANG_W     = 12;
    localparam int SEC_W     = 4;
    localparam int CLS_W     = 2;
    localparam int ROW_W     = 12;
    localparam int CFG_W     = 12;
    localparam int IDX_W     = 2;
    localparam int MIN_DIM   = 3;
    localparam int OUT_DEPTH = 8;
    localparam int OCC_W     = $clog2(OUT_DEPTH + 1);
    localparam int QPTR_W    = $clog2(OUT_DEPTH);

    // angle limits in tenths of a degree
    localparam int ANG_FLAT_LO  = 150;
    localparam int ANG_FLAT_MLO = 1650;
    localparam int ANG_FLAT_MHI = 1950;
    localparam int ANG_FLAT_HI  = 3450;
    localparam int ANG_S1       = 225;
    localparam int ANG_S2       = 675;
    localparam int ANG_S3       = 1125;
    localparam int ANG_S4       = 1575;
    localparam int ANG_S5       = 2025;
    localparam int ANG_S6       = 2475;
    localparam int ANG_S7       = 2925;
    localparam int ANG_S0       = 3375;

    typedef enum logic [IDX_W-1:0] {
        REG_LOW    = 2'd0,
        REG_HIGH   = 2'd1,
        REG_WIDTH  = 2'd2,
        REG_HEIGHT = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } opcode_t;

    typedef enum logic [SEC_W-1:0] {
        SEC_H0    = 4'd0,
        SEC_D45   = 4'd1,
        SEC_V90   = 4'd2,
        SEC_D135  = 4'd3,
        SEC_H180  = 4'd4,
        SEC_D225  = 4'd5,
        SEC_V270  = 4'd6,
        SEC_D315  = 4'd7,
        SEC_FLAT  = 4'd8
    } sector_t;

    localparam logic [CLS_W-1:0] CLS_NONE   = 2'd0;
    localparam logic [CLS_W-1:0] CLS_WEAK   = 2'd1;
    localparam logic [CLS_W-1:0] CLS_STRONG = 2'd2;

    // control of one stream position entering the line stores
    typedef struct packed {
        logic valid;
        logic have;
        logic q_ok;
        logic p_ok;
    } adv_ctl_t;

    // classified position on its way to the hysteresis stage
    typedef struct packed {
        logic             valid;
        logic             p_valid;
        logic [CLS_W-1:0] cls;
    } cls_ctl_t;

    typedef struct packed {
        logic edge_res;
        logic frame_end;
    } result_t;

    function automatic logic [SEC_W-1:0] sector_of(input logic [ANG_W-1:0] a);
        logic [SEC_W-1:0] s;
        if ((a inside {[ANG_FLAT_MLO:ANG_FLAT_MHI]}) || a <= ANG_FLAT_LO || a >= ANG_FLAT_HI)
            s = SEC_FLAT;
        else if (a < ANG_S1 || a >= ANG_S0)
            s = SEC_H0;
        else if (a < ANG_S2)
            s = SEC_D45;
        else if (a < ANG_S3)
            s = SEC_V90;
        else if (a < ANG_S4)
            s = SEC_D135;
        else if (a < ANG_S5)
            s = SEC_H180;
        else if (a < ANG_S6)
            s = SEC_D225;
        else if (a < ANG_S7)
            s = SEC_V270;
        else
            s = SEC_D315;
        return s;
    endfunction

endpackage

/* hw/rtl/cnh_nms.sv */
// magnitude/sector line store, 3x3 magnitude window and non-maximum suppression
// depends on cnh_pkg
module cnh_nms #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                clr,
    input  cnh_pkg::adv_ctl_t                   adv,
    input  logic [$clog2(MAX_WIDTH)-1:0]        adv_ptr,
    input  logic [cnh_pkg::MAG_W-1:0]           adv_mag,
    input  logic [cnh_pkg::SEC_W-1:0]           adv_sec,
    input  logic [cnh_pkg::MAG_W-1:0]           low_thr,
    input  logic [cnh_pkg::MAG_W-1:0]           high_thr,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]      img_w,
    input  logic [cnh_pkg::ROW_W-1:0]           img_h,
    output cnh_pkg::cls_ctl_t                   cls_out,
    output logic [$clog2(MAX_WIDTH)-1:0]        cls_ptr,
    output logic [1:0]                          occ
);
    import cnh_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    typedef struct packed {
        logic [MAG_W-1:0] old_mag;
        logic             old_have;
        logic [MAG_W-1:0] new_mag;
        logic [SEC_W-1:0] new_sec;
        logic             new_have;
    } mline_t;

    mline_t           line_mem [MAX_WIDTH];
    mline_t           rd_reg;

    logic             s1_v_reg, s2_v_reg;
    logic [MAG_W-1:0] s1_mag_reg;
    logic [SEC_W-1:0] s1_sec_reg;
    logic             s1_have_reg, s1_qok_reg, s1_pok_reg;
    logic [AW-1:0]    s1_ptr_reg, s2_ptr_reg;
    logic             s2_qok_reg, s2_pok_reg;

    logic [MAG_W-1:0] win_reg [3][3];   // [row][col], row 0 newest line, col 0 newest pixel
    logic [SEC_W-1:0] sec_reg [2];
    logic             hq_reg  [2];
    logic             hp_reg  [3];

    logic [ROW_W-1:0] qy_reg;
    logic [AW-1:0]    qx_reg;

    cls_ctl_t         cls_reg;
    logic [AW-1:0]    cls_ptr_reg;

    logic             q_valid, inner, sup;
    logic [MAG_W-1:0] center, nb_a, nb_b, s_val;
    logic [CLS_W-1:0] cls_q;

    // line store: entry holds positions w and 2w back
    always_ff @(posedge clk)
    begin
        if (adv.valid)
            rd_reg <= line_mem[adv_ptr];
        if (s1_v_reg)
            line_mem[s1_ptr_reg] <= '{old_mag: rd_reg.new_mag, old_have: rd_reg.new_have,
                                      new_mag: s1_mag_reg, new_sec: s1_sec_reg,
                                      new_have: s1_have_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= adv.valid;
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.valid)
        begin
            s1_mag_reg  <= adv_mag;
            s1_sec_reg  <= adv_sec;
            s1_have_reg <= adv.have;
            s1_qok_reg  <= adv.q_ok;
            s1_pok_reg  <= adv.p_ok;
            s1_ptr_reg  <= adv_ptr;
        end
        if (s1_v_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][2] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][0];
            end
            win_reg[0][0] <= s1_mag_reg;
            win_reg[1][0] <= rd_reg.new_mag;
            win_reg[2][0] <= rd_reg.old_mag;
            sec_reg[1]    <= sec_reg[0];
            sec_reg[0]    <= rd_reg.new_sec;
            hq_reg[1]     <= hq_reg[0];
            hq_reg[0]     <= rd_reg.new_have;
            hp_reg[2]     <= hp_reg[1];
            hp_reg[1]     <= hp_reg[0];
            hp_reg[0]     <= rd_reg.old_have;
            s2_qok_reg    <= s1_qok_reg;
            s2_pok_reg    <= s1_pok_reg;
            s2_ptr_reg    <= s1_ptr_reg;
        end
    end

    // suppression and threshold classification of the window center
    always_comb
    begin
        center  = win_reg[1][1];
        q_valid = s2_v_reg && s2_qok_reg && hq_reg[1];
        inner   = (qy_reg != '0) && ((ROW_W+1)'(qy_reg) + 1'b1 < (ROW_W+1)'(img_h)) &&
                  (qx_reg != '0) && (WW'(qx_reg) + WW'(1) < img_w);
        nb_a = win_reg[1][0];
        nb_b = win_reg[1][2];
        case (sec_reg[1])
            SEC_H0, SEC_H180:
            begin
                nb_a = win_reg[1][0];
                nb_b = win_reg[1][2];
            end
            SEC_D45, SEC_D315:
            begin
                nb_a = win_reg[0][2];
                nb_b = win_reg[2][0];
            end
            SEC_V90, SEC_V270:
            begin
                nb_a = win_reg[0][1];
                nb_b = win_reg[2][1];
            end
            SEC_D135, SEC_D225:
            begin
                nb_a = win_reg[2][2];
                nb_b = win_reg[0][0];
            end
            default:
            begin
                nb_a = win_reg[1][2];
                nb_b = win_reg[1][0];
            end
        endcase
        // near horizontal: a tie suppresses
        if (sec_reg[1] == SEC_FLAT || sec_reg[1] > SEC_FLAT)
            sup = (center <= nb_a) || (center <= nb_b);
        else
            sup = (center < nb_a) || (center < nb_b);
        s_val = (inner && sup) ? '0 : center;
        if (s_val >= high_thr)
            cls_q = inner ? CLS_STRONG : CLS_NONE;
        else if (s_val >= low_thr)
            cls_q = CLS_WEAK;
        else
            cls_q = CLS_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cls_reg <= '0;
            qy_reg  <= '0;
            qx_reg  <= '0;
        end
        else
        begin
            cls_reg.valid   <= s2_v_reg;
            cls_reg.p_valid <= s2_v_reg && s2_pok_reg && hp_reg[2];
            cls_reg.cls     <= q_valid ? cls_q : CLS_NONE;
            if (clr)
            begin
                qy_reg <= '0;
                qx_reg <= '0;
            end
            else if (q_valid)
            begin
                if (WW'(qx_reg) + WW'(1) == img_w)
                begin
                    qx_reg <= '0;
                    qy_reg <= (qy_reg + 1'b1 == img_h) ? '0 : qy_reg + 1'b1;
                end
                else
                    qx_reg <= qx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_v_reg)
            cls_ptr_reg <= s2_ptr_reg;
    end

    assign cls_out = cls_reg;
    assign cls_ptr = cls_ptr_reg;
    assign occ     = 2'(s1_v_reg) + 2'(s2_v_reg) + 2'(cls_reg.valid);

endmodule

/* hw/rtl/cnh_hyst.sv */
// class line store, 3x3 class window and single-pass hysteresis decision
// depends on cnh_pkg
module cnh_hyst #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                clr,
    input  cnh_pkg::cls_ctl_t                   cls_in,
    input  logic [$clog2(MAX_WIDTH)-1:0]        cls_ptr,
    input  logic [$clog2(MAX_WIDTH+1)-1:0]      img_w,
    input  logic [cnh_pkg::ROW_W-1:0]           img_h,
    output logic                                push,
    output cnh_pkg::result_t                    push_data,
    output logic [1:0]                          occ
);
    import cnh_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    typedef struct packed {
        logic [CLS_W-1:0] old_cls;
        logic [CLS_W-1:0] new_cls;
    } cline_t;

    cline_t           class_mem [MAX_WIDTH];
    cline_t           rd_reg;

    logic             s4_v_reg, s5_v_reg;
    logic             s4_pv_reg, s5_pv_reg;
    logic [CLS_W-1:0] s4_cls_reg;
    logic [AW-1:0]    s4_ptr_reg;
    logic [CLS_W-1:0] cwin_reg [3][3];

    logic [ROW_W-1:0] py_reg;
    logic [AW-1:0]    px_reg;

    logic             ok_row [3];
    logic             ok_col [3];
    logic             near_strong, x_last;

    always_ff @(posedge clk)
    begin
        if (cls_in.valid)
        begin
            rd_reg     <= class_mem[cls_ptr];
            s4_cls_reg <= cls_in.cls;
            s4_pv_reg  <= cls_in.p_valid;
            s4_ptr_reg <= cls_ptr;
        end
        if (s4_v_reg)
        begin
            class_mem[s4_ptr_reg] <= '{old_cls: rd_reg.new_cls, new_cls: s4_cls_reg};
            for (int r = 0; r < 3; r++)
            begin
                cwin_reg[r][2] <= cwin_reg[r][1];
                cwin_reg[r][1] <= cwin_reg[r][0];
            end
            cwin_reg[0][0] <= s4_cls_reg;
            cwin_reg[1][0] <= rd_reg.new_cls;
            cwin_reg[2][0] <= rd_reg.old_cls;
            s5_pv_reg      <= s4_pv_reg;
        end
    end

    // neighbor rows/cols that lie inside the frame
    always_comb
    begin
        x_last    = (WW'(px_reg) + WW'(1) == img_w);
        ok_row[0] = ((ROW_W+1)'(py_reg) + 1'b1 < (ROW_W+1)'(img_h));
        ok_row[1] = 1'b1;
        ok_row[2] = (py_reg != '0);
        ok_col[0] = !x_last;
        ok_col[1] = 1'b1;
        ok_col[2] = (px_reg != '0);
        near_strong = 1'b0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (!(r == 1 && c == 1) && ok_row[r] && ok_col[c] &&
                    cwin_reg[r][c] == CLS_STRONG)
                    near_strong = 1'b1;
            end
        end
        push               = s5_v_reg && s5_pv_reg;
        push_data.edge_res = (cwin_reg[1][1] == CLS_STRONG) ||
                             (cwin_reg[1][1] == CLS_WEAK && near_strong);
        push_data.frame_end = x_last && (py_reg + 1'b1 == img_h);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            py_reg   <= '0;
            px_reg   <= '0;
        end
        else
        begin
            s4_v_reg <= cls_in.valid;
            s5_v_reg <= s4_v_reg;
            if (clr)
            begin
                py_reg <= '0;
                px_reg <= '0;
            end
            else if (push)
            begin
                if (x_last)
                begin
                    px_reg <= '0;
                    py_reg <= (py_reg + 1'b1 == img_h) ? '0 : py_reg + 1'b1;
                end
                else
                    px_reg <= px_reg + 1'b1;
            end
        end
    end

    assign occ = 2'(s4_v_reg) + 2'(s5_v_reg);

endmodule

/* hw/rtl/cnh_out_fifo.sv */
// result queue between the pipeline and the output channel
// depends on cnh_pkg
module cnh_out_fifo (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  cnh_pkg::result_t            push_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output cnh_pkg::result_t            out_data,
    output logic [cnh_pkg::OCC_W-1:0]   count
);
    import cnh_pkg::*;

    result_t           q_reg [OUT_DEPTH];
    logic [QPTR_W-1:0] wr_reg, rd_reg;
    logic [OCC_W-1:0]  cnt_reg;
    logic              pop;

    assign out_valid = (cnt_reg != '0);
    assign out_data  = q_reg[rd_reg];
    assign pop       = out_valid && out_ready;
    assign count     = cnt_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + OCC_W'(push) - OCC_W'(pop);
        end
    end

endmodule

/* hw/rtl/canny_nms_hysteresis_unit.sv */
// top level of the canny non-maximum suppression and double-threshold block
// depends on cnh_pkg, cnh_nms, cnh_hyst, cnh_out_fifo
//
// Takes one item per clock (pixel or drain) and sustains that rate as long as results are
// taken. A pixel's result leaves 2*image_width+2 stream positions after it entered, plus the
// pipe registers for line store read, window shift, suppression, class store read and
// class window shift, with the hysteresis decision written straight into the result queue.
// Both line stores are single-port-read memories of MAX_WIDTH entries, each read once and
// written once per stream position. Input ready is set by an eight-entry result queue on a
// credit basis, so a stalled output blocks input only once the queued results plus the items
// in the pipe reach that depth. After the last row, drain items (taken only at a frame start)
// push empty positions to flush the remaining results; other drains are accepted and dropped.
// There is no clearing pass: a width or height write resets the frame position at once, but
// items already in flight are not cancelled. Configuration is meant to be written while idle.
module canny_nms_hysteresis_unit #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [cnh_pkg::IDX_W-1:0]       cfg_index,
    input  logic [cnh_pkg::CFG_W-1:0]       cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            opcode,
    input  logic [cnh_pkg::MAG_W-1:0]       grad_magnitude,
    input  logic [cnh_pkg::ANG_W-1:0]       grad_angle,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            edge_res,
    output logic                            frame_end
);
    import cnh_pkg::*;

    localparam int AW      = $clog2(MAX_WIDTH);
    localparam int WW      = $clog2(MAX_WIDTH + 1);
    localparam int CAP     = 2 * MAX_WIDTH + 2;
    localparam int CNT_W   = $clog2(CAP + 1);
    localparam int W_RESET = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;

    // configuration
    logic [MAG_W-1:0] low_reg, high_reg;
    logic [WW-1:0]    w_reg, w_clamp;
    logic [ROW_W-1:0] h_reg, h_clamp;
    logic             clr;

    // stream position state
    logic [ROW_W-1:0] row_reg;
    logic [AW-1:0]    col_reg;
    logic [AW-1:0]    ptr_reg;
    logic [CNT_W-1:0] n_reg;     // positions since the last clear, saturating
    logic [CNT_W-1:0] age_reg;   // positions since the last pixel, saturating

    logic             acc, adv_go, is_pixel, drain_ok;
    adv_ctl_t         adv;
    logic [SEC_W-1:0] sec_in;

    cls_ctl_t         cls_bus;
    logic [AW-1:0]    cls_ptr;
    logic [1:0]       occ_nms, occ_hyst;
    logic             push;
    result_t          push_data, out_data;
    logic [OCC_W-1:0] q_count;

    // width/height saturation
    always_comb
    begin
        if (cfg_data < CFG_W'(MIN_DIM))
            w_clamp = WW'(MIN_DIM);
        else if (32'(cfg_data) > MAX_WIDTH)
            w_clamp = WW'(MAX_WIDTH);
        else
            w_clamp = WW'(cfg_data);
        if (cfg_data < CFG_W'(MIN_DIM))
            h_clamp = ROW_W'(MIN_DIM);
        else
            h_clamp = cfg_data;
    end

    assign clr = cfg_wr_en && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= MAG_W'(50);
            high_reg <= MAG_W'(150);
            w_reg    <= WW'(W_RESET);
            h_reg    <= ROW_W'(480);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LOW:    low_reg  <= cfg_data[MAG_W-1:0];
                REG_HIGH:   high_reg <= cfg_data[MAG_W-1:0];
                REG_WIDTH:  w_reg    <= w_clamp;
                REG_HEIGHT: h_reg    <= h_clamp;
                default:    ;
            endcase
        end
    end

    // item intake: a drain only moves the stream at a frame start with results pending
    assign acc      = in_valid && in_ready;
    assign is_pixel = (opcode == OP_PIXEL);
    assign drain_ok = (row_reg == '0) && (col_reg == '0) &&
                      (age_reg <= CNT_W'({w_reg, 1'b0}) + CNT_W'(1));
    assign adv_go   = acc && (is_pixel || drain_ok);
    assign sec_in   = sector_of(grad_angle);

    always_comb
    begin
        adv.valid = adv_go;
        adv.have  = is_pixel;
        adv.q_ok  = (n_reg >= CNT_W'(w_reg) + CNT_W'(1));
        adv.p_ok  = (n_reg >= CNT_W'({w_reg, 1'b0}) + CNT_W'(2));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
            ptr_reg <= '0;
            n_reg   <= '0;
            age_reg <= CNT_W'(CAP);
        end
        else if (clr)
        begin
            row_reg <= '0;
            col_reg <= '0;
            ptr_reg <= '0;
            n_reg   <= '0;
            age_reg <= CNT_W'(CAP);
        end
        else if (adv_go)
        begin
            ptr_reg <= (WW'(ptr_reg) + WW'(1) == w_reg) ? '0 : ptr_reg + 1'b1;
            if (n_reg != CNT_W'(CAP))
                n_reg <= n_reg + 1'b1;
            if (is_pixel)
            begin
                age_reg <= '0;
                if (WW'(col_reg) + WW'(1) == w_reg)
                begin
                    col_reg <= '0;
                    row_reg <= (row_reg + 1'b1 == h_reg) ? '0 : row_reg + 1'b1;
                end
                else
                    col_reg <= col_reg + 1'b1;
            end
            else if (age_reg != CNT_W'(CAP))
                age_reg <= age_reg + 1'b1;
        end
    end

    // suppression stage with the magnitude line store
    cnh_nms #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_nms (
        .clk      (clk),
        .rst_n    (rst_n),
        .clr      (clr),
        .adv      (adv),
        .adv_ptr  (ptr_reg),
        .adv_mag  (grad_magnitude),
        .adv_sec  (sec_in),
        .low_thr  (low_reg),
        .high_thr (high_reg),
        .img_w    (w_reg),
        .img_h    (h_reg),
        .cls_out  (cls_bus),
        .cls_ptr  (cls_ptr),
        .occ      (occ_nms)
    );

    // hysteresis stage with the class line store
    cnh_hyst #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_hyst (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr       (clr),
        .cls_in    (cls_bus),
        .cls_ptr   (cls_ptr),
        .img_w     (w_reg),
        .img_h     (h_reg),
        .push      (push),
        .push_data (push_data),
        .occ       (occ_hyst)
    );

    cnh_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .count     (q_count)
    );

    // credit: every item in the pipe may need a queue slot
    assign in_ready  = ((OCC_W+1)'(q_count) + (OCC_W+1)'(occ_nms) + (OCC_W+1)'(occ_hyst))
                       < (OCC_W+1)'(OUT_DEPTH);
    assign edge_res  = out_data.edge_res;
    assign frame_end = out_data.frame_end;

    // line store pointer stays inside the row
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        WW'(ptr_reg) < w_reg)
        else $error("line store pointer beyond image width");

    // input position stays inside the frame
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (WW'(col_reg) < w_reg) && (row_reg < h_reg))
        else $error("input position outside the frame");

    // a drain in mid-frame leaves the stream untouched
    a_drain_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && opcode == OP_DRAIN && (row_reg != '0 || col_reg != '0) && !cfg_wr_en)
        |=> ($stable(n_reg) && $stable(ptr_reg)))
        else $error("mid-frame drain moved the stream");

    // result queue never overfills
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= OCC_W'(OUT_DEPTH))
        else $error("result queue overflow");

endmodule

/* verif/cnh_checker.sv */
// result checker for canny_nms_hysteresis_unit: tracks config writes, predicts results, compares
// depends on cnh_pkg for the port widths, sector codes and class codes
module cnh_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [cnh_pkg::IDX_W-1:0] cfg_index,
    input  logic [cnh_pkg::CFG_W-1:0] cfg_data,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic                      opcode,
    input  logic [cnh_pkg::MAG_W-1:0] grad_magnitude,
    input  logic [cnh_pkg::ANG_W-1:0] grad_angle,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic                      edge_res,
    input  logic                      frame_end,
    output int                        fail_count,
    output int                        edges_owed
);
    timeunit 1ns;
    timeprecision 1ps;
    import cnh_pkg::*;

    localparam int SLOTS = 8192;

    int unsigned low_th, high_th, img_w, img_h;
    logic [MAG_W-1:0] mag_ring [SLOTS];
    sector_t          dir_ring [SLOTS];
    logic [CLS_W-1:0] cls_ring [SLOTS];
    bit               slot_live [SLOTS];
    int               slot_y [SLOTS];
    int               slot_x [SLOTS];
    int               slot_now, row_cnt, col_cnt, unreported;
    result_t          edge_q[$];

    function automatic sector_t angle_sector(int a);
        if ((a >= 1650 && a <= 1950) || a <= 150 || a >= 3450) return SEC_FLAT;
        if (a < 225 || a >= 3375) return SEC_H0;
        if (a < 675) return SEC_D45;
        if (a < 1125) return SEC_V90;
        if (a < 1575) return SEC_D135;
        if (a < 2025) return SEC_H180;
        if (a < 2475) return SEC_D225;
        if (a < 2925) return SEC_V270;
        return SEC_D315;
    endfunction

    function automatic int slot_at(int q, int dy, int dx);
        return (q + SLOTS + dy * int'(img_w) + dx) % SLOTS;
    endfunction

    // one side of the neighbour pair along the gradient; the other is its mirror
    function automatic void grad_step(sector_t s, output int dy, output int dx);
        case (s)
            SEC_D45:  begin dy = 1;  dx = -1; end
            SEC_V90:  begin dy = 1;  dx = 0;  end
            SEC_D135: begin dy = -1; dx = -1; end
            SEC_D225: begin dy = 1;  dx = 1;  end
            SEC_V270: begin dy = -1; dx = 0;  end
            SEC_D315: begin dy = -1; dx = 1;  end
            default:  begin dy = 0;  dx = 1;  end
        endcase
    endfunction

    function automatic void classify(int q);
        int y, x, dy, dx;
        int unsigned s, na, nb;
        bit inner;
        y = slot_y[q];
        x = slot_x[q];
        s = mag_ring[q];
        inner = y >= 1 && y + 2 <= int'(img_h) && x >= 1 && x + 2 <= int'(img_w);
        if (inner) begin
            grad_step(dir_ring[q], dy, dx);
            na = mag_ring[slot_at(q, dy, dx)];
            nb = mag_ring[slot_at(q, -dy, -dx)];
            if (dir_ring[q] == SEC_FLAT) begin
                if (s <= na || s <= nb) s = 0;
            end
            else if (s < na || s < nb) s = 0;
        end
        if (s >= high_th) cls_ring[q] = inner ? CLS_STRONG : CLS_NONE;
        else if (s >= low_th) cls_ring[q] = CLS_WEAK;
        else cls_ring[q] = CLS_NONE;
    endfunction

    function automatic void flush_frame();
        foreach (slot_live[i]) slot_live[i] = 0;
        row_cnt = 0;
        col_cnt = 0;
        unreported = 0;
    endfunction

    function automatic void stream_step(bit have, int mag, int ang);
        int t, q, p, y, x;
        result_t r;
        t = slot_now;
        slot_live[t] = have;
        if (have) begin
            mag_ring[t] = MAG_W'(mag);
            dir_ring[t] = angle_sector(ang);
            slot_y[t] = row_cnt;
            slot_x[t] = col_cnt;
            unreported++;
            col_cnt++;
            if (col_cnt >= int'(img_w)) begin
                col_cnt = 0;
                row_cnt++;
                if (row_cnt >= int'(img_h)) row_cnt = 0;
            end
        end
        q = (t + SLOTS - int'(img_w) - 1) % SLOTS;
        if (slot_live[q]) classify(q);
        p = (t + SLOTS - 2 * int'(img_w) - 2) % SLOTS;
        if (slot_live[p]) begin
            y = slot_y[p];
            x = slot_x[p];
            r.edge_res = cls_ring[p] == CLS_STRONG;
            if (cls_ring[p] == CLS_WEAK)
                for (int dy = -1; dy <= 1; dy++)
                    for (int dx = -1; dx <= 1; dx++)
                        if ((dy != 0 || dx != 0) && y + dy >= 0 && x + dx >= 0 &&
                            y + dy < int'(img_h) && x + dx < int'(img_w) &&
                            cls_ring[slot_at(p, dy, dx)] == CLS_STRONG)
                            r.edge_res = 1'b1;
            r.frame_end = (y + 1 == int'(img_h)) && (x + 1 == int'(img_w));
            edge_q.push_back(r);
            if (unreported > 0) unreported--;
        end
        slot_now = (t + 1) % SLOTS;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        int unsigned v;
        result_t want;
        if (!rst_n) begin
            low_th = 50;
            high_th = 150;
            img_w = 640;
            img_h = 480;
            slot_now = 0;
            fail_count = 0;
            edge_q.delete();
            flush_frame();
        end
        else begin
            if (out_valid && out_ready) begin
                if (edge_q.size() == 0) begin
                    $error("result item with nothing expected");
                    fail_count++;
                end
                else begin
                    want = edge_q.pop_front();
                    if (edge_res !== want.edge_res) begin
                        $error("edge_res expected %0d actual %0d", want.edge_res, edge_res);
                        fail_count++;
                    end
                    if (frame_end !== want.frame_end) begin
                        $error("frame_end expected %0d actual %0d", want.frame_end, frame_end);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready) begin
                if (opcode == OP_PIXEL)
                    stream_step(1'b1, int'(grad_magnitude), int'(grad_angle));
                else if (row_cnt == 0 && col_cnt == 0 && unreported > 0)
                    stream_step(1'b0, 0, 0);
            end
            if (cfg_wr_en) begin
                v = 32'(cfg_data);
                case (cfg_reg_t'(cfg_index))
                    REG_LOW:  low_th = v & 11'h7ff;
                    REG_HIGH: high_th = v & 11'h7ff;
                    REG_WIDTH: begin
                        img_w = v < 3 ? 3 : (v > 2048 ? 2048 : v);
                        flush_frame();
                    end
                    default: begin
                        img_h = v < 3 ? 3 : v;
                        flush_frame();
                    end
                endcase
            end
        end
        edges_owed = edge_q.size();
    end

endmodule

/* verif/tb.sv */
// stimulus and verdict for canny_nms_hysteresis_unit
// depends on cnh_pkg, the block under test and cnh_checker
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cnh_pkg::*;

    // cycles with no handshake or register write before the run is declared hung
    localparam int STALL_LIMIT = 20000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    cfg_reg_t             cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic                 opcode;
    logic [MAG_W-1:0]     grad_magnitude;
    logic [ANG_W-1:0]     grad_angle;
    logic                 out_valid;
    logic                 out_ready;
    logic                 edge_res;
    logic                 frame_end;
    int                   fail_count;
    int                   edges_owed;

    // idling on both sides is switched off for the last part of the run
    bit                   gaps_on;
    int                   pixels_sent;
    int                   eff_w;
    int                   eff_h;
    int                   quiet_cycles;

    canny_nms_hysteresis_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .grad_magnitude (grad_magnitude),
        .grad_angle     (grad_angle),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .edge_res       (edge_res),
        .frame_end      (frame_end)
    );

    cnh_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .grad_magnitude (grad_magnitude),
        .grad_angle     (grad_angle),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .edge_res       (edge_res),
        .frame_end      (frame_end),
        .fail_count     (fail_count),
        .edges_owed     (edges_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver side: random stall bursts, changed at the falling edge
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready = 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 5);
                out_ready = 1'b0;
            end
            else
                out_ready = 1'b1;
        end
    end

    // hang detection: any handshake or register write restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || cfg_wr_en || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("canny_nms_hysteresis_unit regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // present one item and hold it until taken; valid may drop for a short burst first
    task automatic send_item(opcode_t op, int mag, int ang);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        in_valid = 1'b1;
        opcode = op;
        grad_magnitude = MAG_W'(mag);
        grad_angle = ANG_W'(ang);
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        if (op == OP_PIXEL) pixels_sent++;
    endtask

    // stop sending, let every owed result out, then give the pipe time to settle
    task automatic go_idle();
        in_valid = 1'b0;
        while (edges_owed != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, int val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = CFG_W'(val);
        @(negedge clk);
        cfg_wr_en = 1'b0;
        // track the saturated frame shape for drain counts
        if (idx == REG_WIDTH) eff_w = val < 3 ? 3 : (val > 2048 ? 2048 : val);
        if (idx == REG_HEIGHT) eff_h = val < 3 ? 3 : val;
    endtask

    // magnitudes biased so that strong, weak and quiet pixels all show up
    function automatic int rand_mag();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 2047);
            1: return 0;
            2: return 2047;
            default: return $urandom_range(0, 400);
        endcase
    endfunction

    // one random frame of the current shape, with an occasional ignored mid-frame drain
    task automatic random_frame();
        for (int i = 0; i < eff_w * eff_h; i++)
        begin
            if ($urandom_range(0, 30) == 0 && i > 0)
                send_item(OP_DRAIN, $urandom_range(0, 2047), $urandom_range(0, 4095));
            send_item(OP_PIXEL, rand_mag(), $urandom_range(0, 4095));
        end
    endtask

    // flush the last two rows and two positions; the extra drains are ignored
    task automatic drain_frame();
        repeat (2 * eff_w + 2 + $urandom_range(0, 3))
            send_item(OP_DRAIN, $urandom_range(0, 2047), $urandom_range(0, 4095));
    endtask

    initial
    begin
        int flat_angles[$];
        int phase;
        flat_angles = '{0, 150, 151, 224, 225, 674, 675, 1124, 1125, 1574, 1575, 1649,
                        1650, 1950, 1951, 2024, 2025, 2474, 2475, 2924, 2925, 3374,
                        3375, 3449, 3450, 3599, 4095};
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_LOW;
        cfg_data = '0;
        in_valid = 1'b0;
        opcode = OP_PIXEL;
        grad_magnitude = '0;
        grad_angle = '0;
        gaps_on = 1'b1;
        pixels_sent = 0;
        eff_w = 640;
        eff_h = 480;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: 5x5 frame sweeping every sector boundary, magnitude extremes
        // and a drain in the middle of the frame
        write_reg(REG_WIDTH, 5);
        write_reg(REG_HEIGHT, 5);
        for (int i = 0; i < 25; i++)
        begin
            if (i == 12) send_item(OP_DRAIN, 0, 0);
            send_item(OP_PIXEL, (i % 3 == 0) ? 2047 : ((i % 3 == 1) ? 0 : 100),
                      flat_angles[i]);
        end
        drain_frame();
        go_idle();

        // saturating writes: width and height below the minimum, thresholds at extremes
        write_reg(REG_WIDTH, 0);
        write_reg(REG_HEIGHT, 1);
        write_reg(REG_LOW, 0);
        write_reg(REG_HIGH, 2047);
        random_frame();
        drain_frame();
        go_idle();

        // widest row, shortest frame, broken off after the first few hundred pixels
        write_reg(REG_WIDTH, 4095);
        write_reg(REG_HEIGHT, 3);
        write_reg(REG_LOW, 4095);
        write_reg(REG_HIGH, 1);
        repeat (300) send_item(OP_PIXEL, rand_mag(), $urandom_range(0, 4095));
        go_idle();

        // tallest frame, cut short by the next shape write
        write_reg(REG_WIDTH, 3);
        write_reg(REG_HEIGHT, 4095);
        repeat (40) send_item(OP_PIXEL, rand_mag(), $urandom_range(0, 4095));
        send_item(OP_DRAIN, 0, 0);
        go_idle();

        // random phases: small shapes, random thresholds, some broken-off frames
        phase = 0;
        while (pixels_sent < 1350)
        begin
            if (pixels_sent > 1100) gaps_on = 1'b0;
            write_reg(REG_LOW, $urandom_range(0, 4) == 0 ? $urandom_range(0, 4095)
                                                         : $urandom_range(0, 200));
            write_reg(REG_HIGH, $urandom_range(0, 4) == 0 ? $urandom_range(0, 4095)
                                                          : $urandom_range(100, 500));
            write_reg(REG_WIDTH, $urandom_range(3, 9));
            write_reg(REG_HEIGHT, $urandom_range(3, 7));
            repeat ($urandom_range(1, 3)) random_frame();
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, eff_w * 2))
                    send_item(OP_PIXEL, rand_mag(), $urandom_range(0, 4095));
            else
                drain_frame();
            go_idle();
            phase++;
        end

        if (fail_count == 0)
            $display("canny_nms_hysteresis_unit regression: pass");
        else
            $display("canny_nms_hysteresis_unit regression: fail");
        $finish;
    end

endmodule
